>>> design/sbp_pkg.sv
`default_nettype none
package sbp_pkg;

    // Input word of the block.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  bone_index;
        logic [1:0]  row_index;
        logic [31:0] elem_0;
        logic [31:0] elem_1;
        logic [31:0] elem_2;
        logic [31:0] elem_3;
        logic [7:0]  parent_index;
    } t_in;

    // Output word of the block: one row of a skinning matrix.
    typedef struct packed {
        logic [7:0]  out_bone;
        logic [1:0]  out_row;
        logic [31:0] res_0;
        logic [31:0] res_1;
        logic [31:0] res_2;
        logic [31:0] res_3;
        logic        status;
        logic        last_row;
    } t_out;

    localparam logic [2:0] ACT_ROOT    = 3'd0;
    localparam logic [2:0] ACT_LOCAL   = 3'd1;
    localparam logic [2:0] ACT_POSE    = 3'd2;
    localparam logic [2:0] ACT_INV     = 3'd3;
    localparam logic [2:0] ACT_COMPUTE = 3'd4;

    localparam logic [1:0] MAT_ROOT  = 2'd0;
    localparam logic [1:0] MAT_LOCAL = 2'd1;
    localparam logic [1:0] MAT_POSE  = 2'd2;
    localparam logic [1:0] MAT_INV   = 2'd3;

    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
    localparam logic [31:0] FP_DEF_NAN  = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET    = 32'h0040_0000;

endpackage
`default_nettype wire

>>> design/sbp_ram.sv
`default_nettype none
module sbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> design/skeleton_bone_palette.sv
`default_nettype none
// Skinning matrix palette for a bone hierarchy sorted parent-first, in IEEE
// single precision with round to nearest even. Load words (actions 0..3) write
// one row of the root, local, pose or inverse bind staging matrix. A compute
// word (action 4) forms the bone's model matrix from two 4x4 products, keeps
// it in the model store, and sends the four rows of model*inverse_bind as
// output words, the last marked by last_row. All 192 multiply-add terms of
// the three products run one after another through a single float multiplier
// and adder that share one rounding stage; each term steps through the fetch,
// multiply, round, add and round states, and the output side can stall a
// compute word. A parent that is not an earlier bone is replaced by the
// identity and flags status on all four rows. Bones at or above MAX_BONES are
// computed and sent but not stored. The model store and staging memories
// have no reset; read only what was written.
module skeleton_bone_palette #(
    parameter int MAX_BONES = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sbp_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sbp_pkg::t_out      o_out
);
    import sbp_pkg::*;

    localparam int MS_DEPTH = MAX_BONES * 16;
    localparam int MS_AW    = $clog2(MS_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_MRND  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_ARND  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Unrounded value sig/2^48 * 2^(exp-127), or a finished special value.
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [12:0] exp;
        logic [49:0]        sig;
    } t_rin;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic t_rin fp_mul(input logic [31:0] x, input logic [31:0] y);
        t_rin        o;
        logic [23:0] mx;
        logic [23:0] my;
        logic [47:0] prod;
        logic [7:0]  ex;
        logic [7:0]  ey;
        o.spec     = 1'b0;
        o.spec_val = FP_ZERO;
        o.sign     = x[31] ^ y[31];
        ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx   = {x[30:23] != 8'd0, x[22:0]};
        my   = {y[30:23] != 8'd0, y[22:0]};
        prod = mx * my;
        o.sig = {prod, 2'b00};
        o.exp = $signed({5'd0, ex}) + $signed({5'd0, ey}) - 13'sd127;
        if (is_nan(x)) begin
            o.spec = 1'b1;
            o.spec_val = x | FP_QUIET;
        end else if (is_nan(y)) begin
            o.spec = 1'b1;
            o.spec_val = y | FP_QUIET;
        end else if ((is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y))) begin
            o.spec = 1'b1;
            o.spec_val = FP_DEF_NAN;
        end else if (is_inf(x) || is_inf(y)) begin
            o.spec = 1'b1;
            o.spec_val = {o.sign, 8'hFF, 23'd0};
        end
        return o;
    endfunction

    function automatic t_rin fp_add(input logic [31:0] x, input logic [31:0] y);
        t_rin        o;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [49:0] bs;
        logic [49:0] ss;
        logic [49:0] al;
        logic        st;
        logic [49:0] sum;
        if (x[30:0] >= y[30:0]) begin
            big = x;
            sml = y;
        end else begin
            big = y;
            sml = x;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        bs  = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
        ss  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
        al  = ss >> d;
        st  = |(ss & ~({50{1'b1}} << d));
        al  = {al[49:1], al[0] | st};
        sum = (x[31] == y[31]) ? (bs + al) : (bs - al);
        o.spec     = 1'b0;
        o.spec_val = FP_ZERO;
        o.sig      = sum;
        o.exp      = $signed({5'd0, eb});
        // An exact zero keeps a negative sign only when both inputs are negative.
        o.sign     = (sum == 50'd0) ? (x[31] & y[31]) : big[31];
        if (is_nan(x)) begin
            o.spec = 1'b1;
            o.spec_val = x | FP_QUIET;
        end else if (is_nan(y)) begin
            o.spec = 1'b1;
            o.spec_val = y | FP_QUIET;
        end else if (is_inf(x) && is_inf(y) && (x[31] != y[31])) begin
            o.spec = 1'b1;
            o.spec_val = FP_DEF_NAN;
        end else if (is_inf(x)) begin
            o.spec = 1'b1;
            o.spec_val = x;
        end else if (is_inf(y)) begin
            o.spec = 1'b1;
            o.spec_val = y;
        end
        return o;
    endfunction

    function automatic logic [31:0] fp_round(input t_rin x);
        logic [5:0]         lead;
        logic signed [12:0] lead_s;
        logic signed [12:0] ep;
        logic signed [12:0] ls;
        logic signed [12:0] nls;
        logic [5:0]         rs;
        logic [49:0]        t;
        logic               lost;
        logic [22:0]        frac;
        logic               g;
        logic               st;
        logic [7:0]         ef;
        logic [30:0]        mag;
        logic [31:0]        res;
        lead = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (x.sig[i]) begin
                lead = 6'(i);
            end
        end
        lead_s = $signed({7'd0, lead});
        ep = x.exp + lead_s - 13'sd48;
        // Below the normal range the point is fixed at the smallest exponent.
        if (ep >= 13'sd1) begin
            ls = 13'sd48 - lead_s;
        end else begin
            ls = x.exp - 13'sd1;
        end
        nls = -ls;
        if (ls >= 13'sd0) begin
            t    = x.sig << ls[5:0];
            lost = 1'b0;
        end else begin
            rs   = (nls > 13'sd50) ? 6'd50 : nls[5:0];
            t    = x.sig >> rs;
            lost = |(x.sig & ~({50{1'b1}} << rs));
        end
        frac = t[47:25];
        g    = t[24];
        st   = (|t[23:0]) | lost;
        ef   = (ep >= 13'sd1) ? ep[7:0] : 8'd0;
        mag  = {ef, frac} + 31'(g & (st | frac[0]));
        if (x.spec) begin
            res = x.spec_val;
        end else if (x.sig == 50'd0) begin
            res = {x.sign, 31'd0};
        end else if (ep >= 13'sd255) begin
            res = {x.sign, 8'hFF, 23'd0};
        end else begin
            res = {x.sign, mag};
        end
        return res;
    endfunction

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [1:0]       r_prod;
    logic [1:0]       n_prod;
    logic [1:0]       r_r;
    logic [1:0]       n_r;
    logic [1:0]       r_c;
    logic [1:0]       n_c;
    logic [1:0]       r_k;
    logic [1:0]       n_k;
    logic [1:0]       r_mat;
    logic [1:0]       r_lrow;
    logic [31:0]      r_elem [4];
    logic [7:0]       r_bone;
    logic [7:0]       r_parent;
    logic             r_b0;
    logic             r_bad;
    logic             r_store;
    logic [31:0]      r_s;
    logic [31:0]      n_s;
    logic [31:0]      r_p;
    t_rin             r_rin;
    logic [31:0]      r_res [4];
    logic             r_ov;
    t_out             r_out;

    logic [31:0]      rnd;
    logic [31:0]      opa;
    logic [31:0]      opb;
    logic             in_acc;
    logic             out_free;
    logic             term_done;

    logic [5:0]       sa_raddr;
    logic [5:0]       sb_raddr;
    logic [31:0]      sa_q;
    logic [31:0]      sb_q;
    logic             st_we;
    logic [5:0]       st_waddr;
    logic [4:0]       sc_raddr;
    logic [4:0]       sc_waddr;
    logic             sc_we;
    logic [31:0]      sc_q;
    logic [MS_AW-1:0] ms_raddr;
    logic [MS_AW-1:0] ms_waddr;
    logic             ms_we;
    logic [31:0]      ms_q;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign rnd         = fp_round(r_rin);
    assign term_done   = (r_state == S_ARND) && (r_k == 2'd3);

    // Two copies of the staging matrices give two operand reads per cycle.
    assign st_we    = (r_state == S_LOAD);
    assign st_waddr = {r_mat, r_lrow, r_c};
    assign sa_raddr = {r_b0 ? MAT_ROOT : MAT_LOCAL, r_r, r_k};

    always_comb begin
        case (r_prod)
            2'd0:    sb_raddr = {r_b0 ? MAT_LOCAL : MAT_POSE, r_k, r_c};
            2'd1:    sb_raddr = {MAT_POSE, r_k, r_c};
            default: sb_raddr = {MAT_INV, r_k, r_c};
        endcase
    end

    // Scratch holds the first product in the lower half, the model in the upper.
    always_comb begin
        if (r_prod == 2'd1 && r_b0) begin
            sc_raddr = {1'b0, r_r, r_k};
        end else if (r_prod == 2'd1) begin
            sc_raddr = {1'b0, r_k, r_c};
        end else begin
            sc_raddr = {1'b1, r_r, r_k};
        end
    end
    assign sc_we    = term_done && (r_prod != 2'd2);
    assign sc_waddr = {r_prod[0], r_r, r_c};

    assign ms_raddr = MS_AW'({r_parent, r_r, r_k});
    assign ms_waddr = MS_AW'({r_bone, r_r, r_c});
    assign ms_we    = term_done && (r_prod == 2'd1) && r_store;

    sbp_ram #(.WIDTH(32), .DEPTH(64)) u_stage_a (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_elem[r_c]),
        .i_raddr (sa_raddr),
        .o_rdata (sa_q)
    );

    sbp_ram #(.WIDTH(32), .DEPTH(64)) u_stage_b (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_elem[r_c]),
        .i_raddr (sb_raddr),
        .o_rdata (sb_q)
    );

    sbp_ram #(.WIDTH(32), .DEPTH(32)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (rnd),
        .i_raddr (sc_raddr),
        .o_rdata (sc_q)
    );

    sbp_ram #(.WIDTH(32), .DEPTH(MS_DEPTH)) u_model (
        .i_clk   (i_clk),
        .i_we    (ms_we),
        .i_waddr (ms_waddr),
        .i_wdata (rnd),
        .i_raddr (ms_raddr),
        .o_rdata (ms_q)
    );

    always_comb begin
        case (r_prod)
            2'd0: begin
                opa = sa_q;
                opb = sb_q;
            end
            2'd1: begin
                if (r_b0) begin
                    opa = sc_q;
                    opb = sb_q;
                end else begin
                    if (r_bad) begin
                        opa = (r_r == r_k) ? FP_ONE : FP_ZERO;
                    end else begin
                        opa = ms_q;
                    end
                    opb = sc_q;
                end
            end
            default: begin
                opa = sc_q;
                opb = sb_q;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        n_s     = r_s;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_prod = 2'd0;
                    n_r    = 2'd0;
                    n_c    = 2'd0;
                    n_k    = 2'd0;
                    n_s    = FP_ZERO;
                    if (i_in.action == ACT_COMPUTE) begin
                        n_state = S_FETCH;
                    end else if (i_in.action == ACT_ROOT || i_in.action == ACT_LOCAL
                                 || i_in.action == ACT_POSE || i_in.action == ACT_INV) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_c = r_c + 2'd1;
                if (r_c == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: n_state = S_MUL;
            S_MUL:   n_state = S_MRND;
            S_MRND:  n_state = S_ADD;
            S_ADD:   n_state = S_ARND;
            S_ARND: begin
                n_k = r_k + 2'd1;
                if (r_k != 2'd3) begin
                    n_s     = rnd;
                    n_state = S_FETCH;
                end else begin
                    n_s     = FP_ZERO;
                    n_state = S_FETCH;
                    if (r_prod == 2'd2 && r_c == 2'd3) begin
                        n_state = S_OUT;
                    end else if (r_prod == 2'd2) begin
                        n_c = r_c + 2'd1;
                    end else begin
                        {n_r, n_c} = {r_r, r_c} + 4'd1;
                        if (r_r == 2'd3 && r_c == 2'd3) begin
                            n_prod = r_prod + 2'd1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_c = 2'd0;
                    if (r_r == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_r     = r_r + 2'd1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_r    <= n_r;
        r_c    <= n_c;
        r_k    <= n_k;
        r_s    <= n_s;
        if (in_acc) begin
            r_mat     <= i_in.action[1:0];
            r_lrow    <= i_in.row_index;
            r_elem[0] <= i_in.elem_0;
            r_elem[1] <= i_in.elem_1;
            r_elem[2] <= i_in.elem_2;
            r_elem[3] <= i_in.elem_3;
            r_bone    <= i_in.bone_index;
            r_parent  <= i_in.parent_index;
            r_b0      <= (i_in.bone_index == 8'd0);
            r_bad     <= (i_in.bone_index != 8'd0)
                         && ((i_in.parent_index >= i_in.bone_index)
                             || (32'(i_in.parent_index) >= 32'(MAX_BONES)));
            r_store   <= 32'(i_in.bone_index) < 32'(MAX_BONES);
        end
        if (r_state == S_MUL) begin
            r_rin <= fp_mul(opa, opb);
        end else if (r_state == S_ADD) begin
            r_rin <= fp_add(r_s, r_p);
        end
        if (r_state == S_MRND) begin
            r_p <= rnd;
        end
        if (term_done && r_prod == 2'd2) begin
            r_res[r_c] <= rnd;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.out_bone <= r_bone;
            r_out.out_row  <= r_r;
            r_out.res_0    <= r_res[0];
            r_out.res_1    <= r_res[1];
            r_out.res_2    <= r_res[2];
            r_out.res_3    <= r_res[3];
            r_out.status   <= r_bad;
            r_out.last_row <= (r_r == 2'd3);
        end
    end

endmodule
`default_nettype wire
